// ----- hdl/tthb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail history package
// Shared constants, types and state codes for the timed trail history buffer.
// ----------------------------------------------------------------------------
package tthb_pkg;

    // Storage shape
    localparam int DEPTH       = 16;
    localparam int COORD_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);

    // Port field widths
    localparam int NOW_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int COORD_IO_W = 32;
    localparam int INTEN_W   = 9;
    localparam int ALPHA_W   = 7;
    localparam int SLOT_W    = 4;
    localparam int CFG_W     = 16;

    // Timing constants in ms
    localparam logic [STAMP_W-1:0] EXPIRE_MS = 32'd30000;
    localparam logic [STAMP_W-1:0] FULL_MS   = 32'd20000;
    localparam logic [CFG_W-1:0]   SHIFT_RESET = 16'd2000;

    // Peak alpha: floor(intensity * 110 / 256), intensity capped at 1.0
    localparam logic [INTEN_W-1:0] INTEN_MAX   = 9'd256;
    localparam int                 PEAK_PROD_W = 16;
    localparam logic [PEAK_PROD_W-1:0] ALPHA_PEAK = 16'd110;
    localparam int                 PEAK_SHIFT  = 8;

    // Fade: floor(max_a * (30000 - age) / 10000) while age is above 20000.
    // The remaining time is then below 10000 and fits in DIFF_W bits.
    localparam int DIFF_W  = 14;
    localparam int PROD_W  = ALPHA_W + DIFF_W;
    // Divide by 10000 as a multiply by ceil(2^35 / 10000); exact for any
    // product below 2^21.
    localparam int RECIP_W   = 22;
    localparam int DIV_SHIFT = 35;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 22'd3435974;
    localparam int MUL_W     = PROD_W + RECIP_W;

    // Action codes
    localparam logic ACT_REGISTER = 1'b0;
    localparam logic ACT_RENDER   = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pos;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG_RD,
        S_REG_WR,
        S_RND_START,
        S_RND_SCAN,
        S_RND_DRAIN,
        S_RND_FLUSH
    } t_state;

    // Memory read request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

    // Memory write request
    typedef struct packed {
        logic               stamp_we;
        logic               pos_we;
        logic [ADDR_W-1:0]  addr;
        logic [STAMP_W-1:0] stamp;
        t_pos               pos;
    } t_mem_wr;

    // Slot expiry (drops the entry's valid bit)
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_clr;

endpackage

// ----- hdl/tthb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail history channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface tthb_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic [tthb_pkg::NOW_W-1:0]             now_ms;
    logic signed [tthb_pkg::COORD_IO_W-1:0] pos_x;
    logic signed [tthb_pkg::COORD_IO_W-1:0] pos_y;
    logic signed [tthb_pkg::COORD_IO_W-1:0] pos_z;
    logic [tthb_pkg::INTEN_W-1:0]           intensity;

    modport source (
        output valid, action, now_ms, pos_x, pos_y, pos_z, intensity,
        input  ready
    );
    modport sink (
        input  valid, action, now_ms, pos_x, pos_y, pos_z, intensity,
        output ready
    );
endinterface

interface tthb_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tthb_pkg::COORD_IO_W-1:0] out_x;
    logic signed [tthb_pkg::COORD_IO_W-1:0] out_y;
    logic signed [tthb_pkg::COORD_IO_W-1:0] out_z;
    logic [tthb_pkg::ALPHA_W-1:0]           alpha;
    logic [tthb_pkg::SLOT_W-1:0]            slot;
    logic                                   valid_res;
    logic                                   last;

    modport source (
        output valid, out_x, out_y, out_z, alpha, slot, valid_res, last,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, alpha, slot, valid_res, last,
        output ready
    );
endinterface

// ----- hdl/tthb_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail history storage
// Stamp and position memories with one registered read port, one write
// port and per-entry valid bits; an invalid entry reads as stamp zero.
// ----------------------------------------------------------------------------
module tthb_mem (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tthb_pkg::t_mem_rd               i_rd,
    input  tthb_pkg::t_mem_wr               i_wr,
    input  tthb_pkg::t_mem_clr              i_clr,
    output logic [tthb_pkg::STAMP_W-1:0]    o_stamp,
    output tthb_pkg::t_pos                  o_pos
);
    import tthb_pkg::*;

    logic [STAMP_W-1:0] r_stamp_mem [DEPTH];
    t_pos               r_pos_mem   [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [STAMP_W-1:0] r_rd_stamp;
    t_pos               r_rd_pos;
    logic               r_rd_vld;

    // Stamp memory
    always_ff @(posedge i_clk) begin
        if (i_wr.stamp_we) begin
            r_stamp_mem[i_wr.addr] <= i_wr.stamp;
        end
        if (i_rd.en) begin
            r_rd_stamp <= r_stamp_mem[i_rd.addr];
        end
    end

    // Position memory
    always_ff @(posedge i_clk) begin
        if (i_wr.pos_we) begin
            r_pos_mem[i_wr.addr] <= i_wr.pos;
        end
        if (i_rd.en) begin
            r_rd_pos <= r_pos_mem[i_rd.addr];
        end
    end

    // Valid bits: all slots empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clr.en) begin
                r_vld[i_clr.addr] <= 1'b0;
            end
            if (i_wr.stamp_we) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.addr];
            end
        end
    end

    assign o_stamp = r_rd_vld ? r_rd_stamp : '0;
    assign o_pos   = r_rd_pos;

endmodule

// ----- hdl/timed_trail_history_buffer.sv -----
`timescale 1ns / 1ps
// Register word: accept, read slot 0, write back; the next word is taken after the write back.
// Render word: one slot read per cycle while the result side does not stall, four pipeline
//   stages, one final word; the next word is taken once the final word is in the output register.
// A zero peak alpha skips the scan: one empty word, through the start and flush states.
// Synchronous active-low reset empties every slot at once (valid bits, no clearing
// pass) and sets the shift interval to 2000 ms.
// ----------------------------------------------------------------------------
// Timed trail history buffer
// Circular history of timestamped points; register words push or overwrite
// the newest slot, render words scan, expire and emit faded live points.
// ----------------------------------------------------------------------------
module timed_trail_history_buffer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tthb_req_if.sink                    i_req,
    tthb_res_if.source                  o_res,
    input  logic                        i_cfg_we,
    input  logic [tthb_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import tthb_pkg::*;

    localparam logic [ADDR_W-1:0] IDX_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(DEPTH);

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_shift_ms;
    logic [ADDR_W-1:0]  r_head;
    logic [NOW_W-1:0]   r_now;
    t_pos               r_pos;
    logic [ALPHA_W-1:0] r_max_a;
    logic [ADDR_W-1:0]  r_idx;

    // Scan pipeline stages
    logic               r_s1_vld;
    logic [ADDR_W-1:0]  r_s1_idx;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_s2_vld, r_s2_live, r_s2_full;
    logic [DIFF_W-1:0]  r_s2_diff;
    t_pos               r_s2_pos;
    logic [ADDR_W-1:0]  r_s2_idx;
    logic               r_s3_vld, r_s3_live, r_s3_full;
    logic [PROD_W-1:0]  r_s3_prod;
    t_pos               r_s3_pos;
    logic [ADDR_W-1:0]  r_s3_idx;
    logic               r_s4_vld, r_s4_live;
    logic [ALPHA_W-1:0] r_s4_alpha;
    t_pos               r_s4_pos;
    logic [ADDR_W-1:0]  r_s4_idx;

    // Held-back live result, so the final one can carry last
    logic               r_pd_vld;
    logic [ALPHA_W-1:0] r_pd_alpha;
    t_pos               r_pd_pos;
    logic [ADDR_W-1:0]  r_pd_idx;

    // Output register
    logic               r_o_vld;
    t_pos               r_o_pos;
    logic [ALPHA_W-1:0] r_o_alpha;
    logic [ADDR_W-1:0]  r_o_idx;
    logic               r_o_res;
    logic               r_o_last;

    logic               req_acc;
    logic               adv;
    logic               issue;
    logic               pipe_empty;
    logic [ADDR_W:0]    addr_sum;
    logic [ADDR_W-1:0]  scan_addr;
    logic [ADDR_W-1:0]  head_dec;
    logic [STAMP_W-1:0] mem_stamp;
    t_pos               mem_pos;
    t_mem_rd            mem_rd;
    t_mem_wr            mem_wr;
    t_mem_clr           mem_clr;
    logic [STAMP_W-1:0] age0;
    logic               reg_shift;
    logic [STAMP_W-1:0] s1_age;
    logic [STAMP_W-1:0] s1_rem;
    logic               s1_live;
    logic               s1_full;
    logic [MUL_W-1:0]   s3_mul;
    logic [INTEN_W-1:0] inten_c;
    logic [PEAK_PROD_W-1:0] peak_prod;
    logic               push_mid;
    logic               push_fin;

    assign req_acc       = i_req.valid && i_req.ready;
    assign i_req.ready   = (r_state == S_IDLE);
    assign adv           = !r_o_vld || o_res.ready;
    assign issue         = (r_state == S_RND_SCAN) && adv;
    assign pipe_empty    = !r_s1_vld && !r_s2_vld && !r_s3_vld && !r_s4_vld;

    // Logical slot to physical entry, modulo DEPTH
    assign addr_sum  = {1'b0, r_head} + {1'b0, r_idx};
    assign scan_addr = (addr_sum >= DEPTH_EXT) ? ADDR_W'(addr_sum - DEPTH_EXT)
                                               : addr_sum[ADDR_W-1:0];
    assign head_dec  = (r_head == '0) ? IDX_LAST : r_head - 1'b1;

    // Peak alpha of a render word
    assign inten_c   = (i_req.intensity > INTEN_MAX) ? INTEN_MAX : i_req.intensity;
    assign peak_prod = PEAK_PROD_W'(inten_c) * ALPHA_PEAK;

    // Slot 0 age check for a register word
    assign age0      = r_now - mem_stamp;
    assign reg_shift = (mem_stamp != '0) && (age0 > STAMP_W'(r_shift_ms));

    // Stage 1: liveness and remaining fade time
    assign s1_age  = r_now - mem_stamp;
    assign s1_live = (mem_stamp != '0) && (s1_age <= EXPIRE_MS);
    assign s1_full = (s1_age <= FULL_MS);
    assign s1_rem  = EXPIRE_MS - s1_age;

    // Stage 3: divide by the fade window through the reciprocal
    assign s3_mul = MUL_W'(r_s3_prod) * MUL_W'(DIV_RECIP);

    // Result pushes
    assign push_mid = adv && r_s4_vld && r_s4_live && r_pd_vld;
    assign push_fin = adv && (r_state == S_RND_FLUSH);

    tthb_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (mem_rd),
        .i_wr    (mem_wr),
        .i_clr   (mem_clr),
        .o_stamp (mem_stamp),
        .o_pos   (mem_pos)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_state = (i_req.action == ACT_RENDER) ? S_RND_START : S_REG_RD;
                end
            end
            S_REG_RD:    n_state = S_REG_WR;
            S_REG_WR:    n_state = S_IDLE;
            S_RND_START: n_state = (r_max_a == '0) ? S_RND_FLUSH : S_RND_SCAN;
            S_RND_SCAN: begin
                if (issue && (r_idx == IDX_LAST)) begin
                    n_state = S_RND_DRAIN;
                end
            end
            S_RND_DRAIN: begin
                if (pipe_empty) begin
                    n_state = S_RND_FLUSH;
                end
            end
            S_RND_FLUSH: begin
                if (adv) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory control
    always_comb begin
        mem_rd       = '0;
        mem_wr       = '0;
        mem_clr      = '0;
        mem_wr.stamp = r_now;
        mem_wr.pos   = r_pos;
        unique case (r_state)
            S_REG_RD: begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = r_head;
            end
            S_REG_WR: begin
                mem_wr.pos_we   = 1'b1;
                mem_wr.stamp_we = reg_shift || (mem_stamp == '0);
                mem_wr.addr     = reg_shift ? head_dec : r_head;
            end
            S_RND_SCAN: begin
                mem_rd.en   = issue;
                mem_rd.addr = scan_addr;
            end
            default: begin
                mem_rd = '0;
            end
        endcase
        // expire a slot as it leaves stage 1
        mem_clr.en   = r_s1_vld && adv && !s1_live;
        mem_clr.addr = r_s1_addr;
    end

    // State, configuration and history head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_shift_ms <= SHIFT_RESET;
            r_head     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_shift_ms <= i_cfg_wdata;
            end
            if ((r_state == S_REG_WR) && reg_shift) begin
                r_head <= head_dec;
            end
        end
    end

    // Captured request word and scan counter
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_now   <= i_req.now_ms;
            r_pos.x <= t_coord'(i_req.pos_x[COORD_WIDTH-1:0]);
            r_pos.y <= t_coord'(i_req.pos_y[COORD_WIDTH-1:0]);
            r_pos.z <= t_coord'(i_req.pos_z[COORD_WIDTH-1:0]);
            r_max_a <= ALPHA_W'(peak_prod >> PEAK_SHIFT);
        end
        if (r_state == S_RND_START) begin
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= (r_state == S_RND_SCAN);
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_idx   <= r_idx;
            r_s1_addr  <= scan_addr;
            r_s2_live  <= s1_live;
            r_s2_full  <= s1_full;
            r_s2_diff  <= s1_rem[DIFF_W-1:0];
            r_s2_pos   <= mem_pos;
            r_s2_idx   <= r_s1_idx;
            r_s3_live  <= r_s2_live;
            r_s3_full  <= r_s2_full;
            r_s3_prod  <= PROD_W'(r_max_a) * PROD_W'(r_s2_diff);
            r_s3_pos   <= r_s2_pos;
            r_s3_idx   <= r_s2_idx;
            r_s4_live  <= r_s3_live;
            r_s4_alpha <= r_s3_full ? r_max_a : s3_mul[DIV_SHIFT +: ALPHA_W];
            r_s4_pos   <= r_s3_pos;
            r_s4_idx   <= r_s3_idx;
        end
    end

    // Held-back result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pd_vld <= 1'b0;
        end else if (adv && r_s4_vld && r_s4_live) begin
            r_pd_vld <= 1'b1;
        end else if (push_fin) begin
            r_pd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s4_vld && r_s4_live) begin
            r_pd_alpha <= r_s4_alpha;
            r_pd_pos   <= r_s4_pos;
            r_pd_idx   <= r_s4_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (push_mid || push_fin) begin
            r_o_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_mid || (push_fin && r_pd_vld)) begin
            r_o_pos   <= r_pd_pos;
            r_o_alpha <= r_pd_alpha;
            r_o_idx   <= r_pd_idx;
            r_o_res   <= 1'b1;
            r_o_last  <= push_fin;
        end else if (push_fin) begin
            // nothing live: one empty word
            r_o_pos   <= '0;
            r_o_alpha <= '0;
            r_o_idx   <= '0;
            r_o_res   <= 1'b0;
            r_o_last  <= 1'b1;
        end
    end

    assign o_res.valid     = r_o_vld;
    assign o_res.out_x     = COORD_IO_W'(r_o_pos.x);
    assign o_res.out_y     = COORD_IO_W'(r_o_pos.y);
    assign o_res.out_z     = COORD_IO_W'(r_o_pos.z);
    assign o_res.alpha     = r_o_alpha;
    assign o_res.slot      = SLOT_W'(r_o_idx);
    assign o_res.valid_res = r_o_res;
    assign o_res.last      = r_o_last;

endmodule

// ----- sim/timed_trail_history_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail history checker
// Watches the request and result channels of the timed trail history buffer.
// It keeps its own copy of the slot stamps, positions and shift interval,
// works out the point words that each render word produces, and compares
// every accepted result word, field by field, against the oldest expected
// word.
// ----------------------------------------------------------------------------
module timed_trail_history_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tthb_req_if                         i_req,
    tthb_res_if                         i_res,
    input  logic                        i_cfg_we,
    input  logic [tthb_pkg::CFG_W-1:0]  i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_points_due
);
    import tthb_pkg::*;

    localparam logic [STAMP_W-1:0] FADE_MS = 32'd10000;
    localparam int                 MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [COORD_IO_W-1:0] x;
        logic signed [COORD_IO_W-1:0] y;
        logic signed [COORD_IO_W-1:0] z;
        logic [ALPHA_W-1:0]           alpha;
        logic [SLOT_W-1:0]            slot;
        logic                         valid_res;
        logic                         last;
    } t_point_word;

    // Mirror of the block's history and setting
    logic [STAMP_W-1:0] trail_stamp [DEPTH];
    t_pos               trail_pos   [DEPTH];
    logic [CFG_W-1:0]   shift_ms;

    t_point_word expected_points_q [$];
    int          fail_total;

    // Register word: shift when slot 0 is older than the interval, then overwrite slot 0
    function void push_history(input logic [NOW_W-1:0] now, input t_coord x,
                               input t_coord y, input t_coord z);
        logic [STAMP_W-1:0] age;
        logic               moves;
        age   = now - trail_stamp[0];
        moves = (trail_stamp[0] != '0) && (age > {16'd0, shift_ms});
        if (moves) begin
            for (int i = DEPTH - 1; i > 0; i--) begin
                trail_stamp[i] = trail_stamp[i-1];
                trail_pos[i]   = trail_pos[i-1];
            end
        end
        trail_pos[0] = '{x: x, y: y, z: z};
        if (moves || trail_stamp[0] == '0) begin
            trail_stamp[0] = now;
        end
    endfunction

    // Render word: with a nonzero peak alpha, expire old slots and queue one faded point per live slot
    function void scan_history(input logic [NOW_W-1:0] now,
                               input logic [INTEN_W-1:0] intensity);
        logic [INTEN_W-1:0] inten;
        logic [31:0]        peak;
        logic [31:0]        fade;
        logic [STAMP_W-1:0] age;
        t_point_word        held;
        logic               have_held;
        have_held = 1'b0;
        held      = '0;
        inten = (intensity > INTEN_MAX) ? INTEN_MAX : intensity;
        peak  = ({23'd0, inten} * {16'd0, ALPHA_PEAK}) >> PEAK_SHIFT;
        if (peak != 0) begin
            for (int i = 0; i < DEPTH; i++) begin
                age = now - trail_stamp[i];
                if (trail_stamp[i] != '0 && age <= EXPIRE_MS) begin
                    if (have_held) expected_points_q.push_back(held);
                    if (age <= FULL_MS) fade = peak;
                    else                fade = (peak * (EXPIRE_MS - age)) / FADE_MS;
                    held.x         = trail_pos[i].x;
                    held.y         = trail_pos[i].y;
                    held.z         = trail_pos[i].z;
                    held.alpha     = fade[ALPHA_W-1:0];
                    held.slot      = SLOT_W'(i);
                    held.valid_res = 1'b1;
                    held.last      = 1'b0;
                    have_held      = 1'b1;
                end else begin
                    trail_stamp[i] = '0;
                end
            end
        end
        // Nothing live (or scan skipped): a single empty closing word
        if (!have_held) held = '0;
        held.last = 1'b1;
        expected_points_q.push_back(held);
    endfunction

    // Per-edge monitor: result side first, then config and request side
    always @(posedge i_clk) begin
        t_point_word got;
        t_point_word want;
        if (!i_rst_n) begin
            shift_ms   = SHIFT_RESET;
            fail_total = 0;
            expected_points_q.delete();
            for (int i = 0; i < DEPTH; i++) begin
                trail_stamp[i] = '0;
                trail_pos[i]   = '0;
            end
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.x         = i_res.out_x;
                got.y         = i_res.out_y;
                got.z         = i_res.out_z;
                got.alpha     = i_res.alpha;
                got.slot      = i_res.slot;
                got.valid_res = i_res.valid_res;
                got.last      = i_res.last;
                if (expected_points_q.size() == 0) begin
                    if (fail_total < MAX_REPORTS)
                        $display("%t: unexpected result word x=%0d y=%0d z=%0d a=%0d s=%0d v=%0d l=%0d",
                                 $realtime, got.x, got.y, got.z, got.alpha, got.slot,
                                 got.valid_res, got.last);
                    fail_total++;
                end else begin
                    want = expected_points_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.alpha !== want.alpha || got.slot !== want.slot ||
                        got.valid_res !== want.valid_res || got.last !== want.last) begin
                        if (fail_total < MAX_REPORTS) begin
                            $display("%t: result word differs", $realtime);
                            $display("  exp x=%0d y=%0d z=%0d alpha=%0d slot=%0d vres=%0d last=%0d",
                                     want.x, want.y, want.z, want.alpha, want.slot,
                                     want.valid_res, want.last);
                            $display("  got x=%0d y=%0d z=%0d alpha=%0d slot=%0d vres=%0d last=%0d",
                                     got.x, got.y, got.z, got.alpha, got.slot,
                                     got.valid_res, got.last);
                        end
                        fail_total++;
                    end
                end
            end
            if (i_cfg_we) shift_ms = i_cfg_wdata;
            if (i_req.valid && i_req.ready) begin
                if (i_req.action == ACT_REGISTER)
                    push_history(i_req.now_ms, i_req.pos_x, i_req.pos_y, i_req.pos_z);
                else
                    scan_history(i_req.now_ms, i_req.intensity);
            end
        end
        o_fail_count <= fail_total;
        o_points_due <= expected_points_q.size();
    end

endmodule

// ----- sim/timed_trail_history_buffer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed trail history buffer test
// Drives register and render words into the buffer with random gaps on the
// request side and random stalls on the result side. A directed opening
// covers the empty history, time zero, the shift boundary, full and faded
// alpha, the exact expiry age, a zero peak alpha, capped intensity and time
// wrap. Random phases follow under several shift intervals; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module timed_trail_history_buffer_test;
    import tthb_pkg::*;

    localparam int PHASE_ITEMS = 60;
    localparam int NUM_PHASES  = 5;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_wdata;
    int                 scoreboard_fails;
    int                 points_due;
    bit                 req_fast = 1'b0;
    bit                 res_fast = 1'b0;
    logic [NOW_W-1:0]   base_ms;
    logic [CFG_W-1:0]   phase_shift [NUM_PHASES];

    tthb_req_if req_ch ();
    tthb_res_if res_ch ();

    always #5 i_clk = ~i_clk;

    timed_trail_history_buffer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    timed_trail_history_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (scoreboard_fails),
        .o_points_due (points_due)
    );

    // Offer one request word after a random gap; returns at the accepting edge
    task automatic send_word(input logic act, input logic [NOW_W-1:0] now,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [INTEN_W-1:0] inten);
        int gap;
        if ($urandom_range(0, 19) == 0) req_fast = !req_fast;
        gap = req_fast ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.action    <= act;
        req_ch.now_ms    <= now;
        req_ch.pos_x     <= x;
        req_ch.pos_y     <= y;
        req_ch.pos_z     <= z;
        req_ch.intensity <= inten;
        req_ch.valid     <= 1'b1;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
    endtask

    // Unused fields carry random junk
    task automatic push_point(input logic [NOW_W-1:0] now, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z);
        send_word(ACT_REGISTER, now, x, y, z, INTEN_W'($urandom));
    endtask

    task automatic scan_trail(input logic [NOW_W-1:0] now, input logic [INTEN_W-1:0] inten);
        send_word(ACT_RENDER, now, $urandom, $urandom, $urandom, inten);
    endtask

    // Stop offering words and wait until every expected word is back
    task automatic drain_block;
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (points_due != 0) @(posedge i_clk);
        // a register word may still be in flight
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_shift(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random word: time steps mostly short, some into the fade and expiry range
    task automatic random_word;
        int               sel;
        logic [NOW_W-1:0] step;
        logic [INTEN_W-1:0] inten;
        sel = $urandom_range(0, 99);
        if (sel < 60)      step = $urandom_range(0, 3000);
        else if (sel < 85) step = $urandom_range(0, 15000);
        else if (sel < 97) step = $urandom_range(18000, 32000);
        else               step = $urandom;
        base_ms = base_ms + step;
        if ($urandom_range(0, 99) < 55) begin
            push_point(base_ms, $urandom, $urandom, $urandom);
        end else begin
            sel = $urandom_range(0, 9);
            if (sel == 0)      inten = INTEN_W'($urandom_range(0, 2));
            else if (sel == 1) inten = INTEN_MAX;
            else if (sel == 2) inten = INTEN_W'($urandom_range(257, 511));
            else               inten = INTEN_W'($urandom_range(3, 255));
            scan_trail(base_ms, inten);
        end
    endtask

    // Result side: random stalls per word, with stretches of no stall
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 24) == 0) res_fast = !res_fast;
            stall = res_fast ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.action    = ACT_REGISTER;
        req_ch.now_ms    = '0;
        req_ch.pos_x     = '0;
        req_ch.pos_y     = '0;
        req_ch.pos_z     = '0;
        req_ch.intensity = '0;
        phase_shift[0] = 16'd0;
        phase_shift[1] = 16'hFFFF;
        phase_shift[2] = 16'd1;
        phase_shift[3] = CFG_W'($urandom_range(0, 8000));
        phase_shift[4] = SHIFT_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening under the reset interval
        scan_trail(32'd5, 9'd256);                               // empty history
        push_point(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // time zero stays empty
        scan_trail(32'd0, 9'd256);
        push_point(32'd100, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_point(32'd2100, 32'hFFFF_FFFF, 32'h0, 32'h1);      // age equals interval
        push_point(32'd2101, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678); // shift
        scan_trail(32'd20100, 9'd256);                           // last full-alpha age
        scan_trail(32'd20101, 9'd511);                           // capped intensity, fading
        scan_trail(32'd30100, 9'd3);                             // expiry age, alpha zero
        scan_trail(32'd30100, 9'd2);                             // zero peak skips scan
        scan_trail(32'd30101, 9'd300);                           // older slot expires
        scan_trail(32'd30101, 9'd257);
        push_point(32'hFFFF_FF00, $urandom, $urandom, $urandom); // huge age, shift
        push_point(32'h0000_0100, $urandom, $urandom, $urandom); // across wrap
        scan_trail(32'h0000_0200, 9'd255);
        scan_trail(32'hFFFF_0000, 9'd1);
        scan_trail(32'hFFFF_0000, 9'd128);                       // all stamps ahead: cleared

        // Random phases, one shift interval each
        base_ms = $urandom;
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_block();
            write_shift(phase_shift[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) random_word();
        end

        drain_block();
        repeat (40) @(posedge i_clk);
        if (scoreboard_fails == 0 && points_due == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
